/* rtl/prle_pkg.sv */
// Package for the pixel run-length encoder.
// Holds sizes, register indexes and the record and queue entry types.
// No dependencies.
package prle_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int IN_CHANS     = 4;
	localparam int CHAN_LIMIT   = (MAX_CHANNELS < IN_CHANS) ? MAX_CHANNELS : IN_CHANS;

	localparam int CHAN_W   = 8;
	localparam int REP_W    = 8;
	localparam int CFG_W    = 13;
	localparam int LINE_W   = 13;
	localparam int CCNT_W   = 3;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int EW       = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int RUN_MAX  = 255;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd2;

	localparam logic [CFG_W-1:0]  RST_LINE_WIDTH     = 13'd512;
	localparam logic [CFG_W-1:0]  RST_PICTURE_HEIGHT = 13'd512;
	localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT  = 3'd3;

	localparam logic STATUS_RUN = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [IN_CHANS-1:0][CHAN_W-1:0] pix_t;

	typedef struct packed {
		logic             v;
		logic             status;
		logic [REP_W-1:0] rep;
		pix_t             pix;
		logic             last;
	} rec_t;

	// one accepted pixel: an optional closed run, then an optional record ending at this pixel (or an error record)
	typedef struct packed {
		rec_t a;
		rec_t b;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/prle_if.sv */
// Channel interfaces of the pixel run-length encoder: pixel input and run record output.
// No dependencies.
interface prle_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pix_chan0;
	logic [7:0] pix_chan1;
	logic [7:0] pix_chan2;
	logic [7:0] pix_chan3;

	modport source (output valid, pix_chan0, pix_chan1, pix_chan2, pix_chan3, input ready);
	modport sink (input valid, pix_chan0, pix_chan1, pix_chan2, pix_chan3, output ready);
endinterface

interface prle_run_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] repeat_minus_one;
	logic [7:0] run_chan0;
	logic [7:0] run_chan1;
	logic [7:0] run_chan2;
	logic [7:0] run_chan3;
	logic       line_end;

	modport source (output valid, status, repeat_minus_one, run_chan0, run_chan1, run_chan2,
		run_chan3, line_end, input ready);
	modport sink (input valid, status, repeat_minus_one, run_chan0, run_chan1, run_chan2,
		run_chan3, line_end, output ready);
endinterface

/* rtl/prle_front.sv */
// Front end: config registers, run and raster state, classification of each pixel.
// Depends on prle_pkg and prle_pix_if.
module prle_front (
	input  logic                               clk,
	input  logic                               arst_n,
	prle_pix_if.sink                           pix,
	input  logic                               cfg_we,
	input  logic [prle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prle_pkg::CFG_W-1:0]         cfg_data,
	input  prle_pkg::q_stat_t                  q_stat,
	output logic                               push,
	output prle_pkg::entry_t                   push_entry
);
	import prle_pkg::*;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CCNT_W-1:0] chans_q;

	pix_t              held_q;
	logic [REP_W-1:0]  extra_q;
	logic              open_q;
	logic [COL_W-1:0]  column_q;
	logic [LINE_W-1:0] line_q;

	logic [CCNT_W-1:0] nch;
	logic [EW-1:0]     eff_w;
	pix_t              pix_m;
	logic              accept;
	logic              err;
	logic              match;
	pix_t              new_pix;
	logic [REP_W-1:0]  new_extra;
	logic [COL_W:0]    col_next;
	logic              last;
	logic              full_run;

	assign pix.ready = !q_stat.full;
	assign accept    = pix.valid && pix.ready;

	always_comb begin
		if (chans_q == '0) begin
			nch = CCNT_W'(1);
		end else if (chans_q > CCNT_W'(CHAN_LIMIT)) begin
			nch = CCNT_W'(CHAN_LIMIT);
		end else begin
			nch = chans_q;
		end
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
	end

	always_comb begin
		pix_t raw;
		raw = {pix.pix_chan3, pix.pix_chan2, pix.pix_chan1, pix.pix_chan0};
		for (int k = 0; k < IN_CHANS; k++) begin
			pix_m[k] = (CCNT_W'(k) < nch) ? raw[k] : '0;
		end
	end

	always_comb begin
		err       = (column_q == '0) && (line_q >= height_q);
		match     = open_q && (pix_m == held_q);
		new_pix   = match ? held_q : pix_m;
		new_extra = match ? extra_q + REP_W'(1) : '0;
		col_next  = {1'b0, column_q} + (COL_W+1)'(1);
		last      = EW'(col_next) >= eff_w;
		full_run  = new_extra == REP_W'(RUN_MAX);

		push_entry.a = '{v: open_q && !match, status: STATUS_RUN, rep: extra_q,
			pix: held_q, last: 1'b0};
		push_entry.b = '{v: last || full_run, status: STATUS_RUN, rep: new_extra,
			pix: new_pix, last: last};
		if (err) begin
			push_entry.a = '0;
			push_entry.b = '{v: 1'b1, status: STATUS_ERR, rep: '0, pix: '0, last: 1'b0};
		end
		push = accept && (push_entry.a.v || push_entry.b.v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_LINE_WIDTH;
			height_q <= RST_PICTURE_HEIGHT;
			chans_q  <= RST_CHANNEL_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:     width_q  <= cfg_data;
				CFG_PICTURE_HEIGHT: height_q <= cfg_data;
				CFG_CHANNEL_COUNT:  chans_q  <= cfg_data[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			extra_q  <= '0;
			open_q   <= 1'b0;
			column_q <= '0;
			line_q   <= '0;
		end else if (accept && !err) begin
			held_q <= new_pix;
			if (last) begin
				open_q   <= 1'b0;
				extra_q  <= '0;
				column_q <= '0;
				line_q   <= line_q + LINE_W'(1);
			end else if (full_run) begin
				open_q   <= 1'b0;
				extra_q  <= '0;
				column_q <= col_next[COL_W-1:0];
			end else begin
				open_q   <= 1'b1;
				extra_q  <= new_extra;
				column_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

/* rtl/prle_queue.sv */
// Short queue of classified pixel entries between front and back end.
// Depends on prle_pkg.
module prle_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  prle_pkg::entry_t  push_entry,
	input  logic              pop,
	output prle_pkg::entry_t  head,
	output prle_pkg::q_stat_t q_stat
);
	import prle_pkg::*;

	entry_t            mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
`endif

endmodule

/* rtl/prle_back.sv */
// Back end: expands queue entries into one or two run records, output register.
// Depends on prle_pkg and prle_run_if.
module prle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  prle_pkg::entry_t  head,
	input  prle_pkg::q_stat_t q_stat,
	output logic              pop,
	prle_run_if.source        run
);
	import prle_pkg::*;

	logic phase_q;
	logic out_valid_q;
	rec_t out_rec_q;
	logic sel_a;
	logic take;
	rec_t rec;

	assign sel_a = !phase_q && head.a.v;
	assign rec   = sel_a ? head.a : head.b;
	assign take  = !q_stat.empty && (!out_valid_q || run.ready);
	assign pop   = take && !(sel_a && head.b.v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			phase_q     <= sel_a && head.b.v;
			out_valid_q <= 1'b1;
		end else if (run.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_rec_q <= rec;
		end
	end

	assign run.valid            = out_valid_q;
	assign run.status           = out_rec_q.status;
	assign run.repeat_minus_one = out_rec_q.rep;
	assign run.run_chan0        = out_rec_q.pix[0];
	assign run.run_chan1        = out_rec_q.pix[1];
	assign run.run_chan2        = out_rec_q.pix[2];
	assign run.run_chan3        = out_rec_q.pix[3];
	assign run.line_end         = out_rec_q.last;

`ifndef SYNTHESIS
	a_phase_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !q_stat.empty)
		else $error("second record pending with empty queue");
	a_phase_two_recs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head.a.v && head.b.v))
		else $error("second record pending on single-record entry");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rec_q.status == STATUS_ERR) |->
		(out_rec_q.rep == '0 && out_rec_q.pix == '0 && !out_rec_q.last))
		else $error("error record carries payload");
`endif

endmodule

/* rtl/pixel_run_length_encoder_core.sv */
// Pixel run-length encoder, top level.
// Depends on prle_pkg, prle_if, prle_front, prle_queue and prle_back.
//
// Accepts one pixel per cycle while the queue is not full and emits run records (length
// minus one plus the run pixel); runs close on a pixel change, at 256 pixels and at each
// line end. The front end classifies each pixel combinationally and writes at most one
// entry to a four-deep queue; the back end turns each entry into one or two records via
// a single output register: a record passes the queue, then the output register, and a
// second record from the same entry follows the first. The output register moves one
// record per cycle while the sink is ready, which sets the sustained rate: one pixel per
// cycle as long as records average no more than one per pixel, with the queue absorbing
// the extra record of a pixel that both breaks a run and ends a line. Pixels past the last
// line yield error records until reset or a larger height. Config writes apply at once.
module pixel_run_length_encoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	prle_pix_if.sink                       pix,
	prle_run_if.source                     run,
	input  logic                           cfg_we,
	input  logic [prle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prle_pkg::CFG_W-1:0]     cfg_data
);
	import prle_pkg::*;

	logic    push;
	entry_t  push_entry;
	logic    pop;
	entry_t  head;
	q_stat_t q_stat;

	prle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	prle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	prle_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.run    (run)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pixel_run_length_encoder_core: directed and random pixel
// streams against a built-in run-length predictor, with random stalls on both channels.
// Depends on prle_pkg, prle_if and the encoder RTL.
module testbench;
	import prle_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PIXEL_TARGET = 750;
	localparam int CALM_TAIL    = 120;

	typedef struct {
		logic             status;
		logic [REP_W-1:0] rep;
		pix_t             pix;
		logic             line_end;
	} run_rec_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	prle_pix_if pix_ch();
	prle_run_if run_ch();

	pixel_run_length_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.run      (run_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pix_t     pending_pixels[$];
	run_rec_t expected_runs[$];
	int       pixels_queued;
	int       pixels_taken;
	int       fail_count;
	int       idle_cycles;
	int       pix_gap;
	int       run_gap;
	bit       stall_enable;

	// encoder shadow: registers and run state
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [CCNT_W-1:0] chan_reg;
	pix_t              held_pix;
	int                run_extra_cnt;
	bit                run_held;
	int                column_cnt;
	logic [LINE_W-1:0] lines_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_channels();
		int n;
		n = int'(chan_reg);
		if (n < 1)
			n = 1;
		if (n > CHAN_LIMIT)
			n = CHAN_LIMIT;
		return n;
	endfunction

	function automatic void push_run(logic status, int rep, pix_t p, logic le);
		run_rec_t r;
		r.status   = status;
		r.rep      = REP_W'(rep);
		r.pix      = p;
		r.line_end = le;
		expected_runs.push_back(r);
	endfunction

	function automatic void encode_pixel(pix_t in_pix);
		pix_t masked;
		int   nch;
		int   wid;
		masked = '0;
		nch = active_channels();
		wid = int'(width_reg);
		if (wid < 1)
			wid = 1;
		if (wid > MAX_WIDTH)
			wid = MAX_WIDTH;
		if (column_cnt == 0 && lines_done >= height_reg) begin
			push_run(STATUS_ERR, 0, '0, 1'b0);
			return;
		end
		for (int k = 0; k < nch; k++)
			masked[k] = in_pix[k];
		if (run_held && masked == held_pix) begin
			run_extra_cnt++;
		end else begin
			if (run_held)
				push_run(STATUS_RUN, run_extra_cnt, held_pix, 1'b0);
			held_pix = masked;
			run_extra_cnt = 0;
			run_held = 1'b1;
		end
		column_cnt++;
		if (column_cnt >= wid) begin
			push_run(STATUS_RUN, run_extra_cnt, held_pix, 1'b1);
			run_held = 1'b0;
			run_extra_cnt = 0;
			column_cnt = 0;
			lines_done = lines_done + LINE_W'(1);
		end else if (run_extra_cnt >= RUN_MAX) begin
			push_run(STATUS_RUN, run_extra_cnt, held_pix, 1'b0);
			run_held = 1'b0;
			run_extra_cnt = 0;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// pixel driver
	always @(posedge clk) begin
		pix_t next_pix;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (pix_gap > 0) begin
				pix_ch.valid <= 1'b0;
				pix_gap--;
			end else if (pending_pixels.size() > 0) begin
				next_pix = pending_pixels.pop_front();
				pix_ch.valid     <= 1'b1;
				pix_ch.pix_chan0 <= next_pix[0];
				pix_ch.pix_chan1 <= next_pix[1];
				pix_ch.pix_chan2 <= next_pix[2];
				pix_ch.pix_chan3 <= next_pix[3];
				if (stall_enable && $urandom_range(0, 7) == 0)
					pix_gap = $urandom_range(1, 18);
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// record sink backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			run_ch.ready <= 1'b0;
		end else if (run_gap > 0) begin
			run_ch.ready <= 1'b0;
			run_gap--;
		end else begin
			run_ch.ready <= 1'b1;
			if (stall_enable && $urandom_range(0, 9) == 0)
				run_gap = $urandom_range(1, 18);
		end
	end

	// monitor: predict on pixel transactions, check record transactions
	always @(posedge clk) begin
		run_rec_t want;
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready) begin
				encode_pixel({pix_ch.pix_chan3, pix_ch.pix_chan2,
					pix_ch.pix_chan1, pix_ch.pix_chan0});
				pixels_taken++;
			end
			if (run_ch.valid && run_ch.ready) begin
				if (expected_runs.size() == 0) begin
					$error("run record transaction with no record expected");
					fail_count++;
				end else begin
					want = expected_runs.pop_front();
					check_field("status", 32'(want.status), 32'(run_ch.status));
					check_field("repeat_minus_one", 32'(want.rep),
						32'(run_ch.repeat_minus_one));
					check_field("run_chan0", 32'(want.pix[0]), 32'(run_ch.run_chan0));
					check_field("run_chan1", 32'(want.pix[1]), 32'(run_ch.run_chan1));
					check_field("run_chan2", 32'(want.pix[2]), 32'(run_ch.run_chan2));
					check_field("run_chan3", 32'(want.pix[3]), 32'(run_ch.run_chan3));
					check_field("line_end", 32'(want.line_end), 32'(run_ch.line_end));
				end
			end
			if ((pix_ch.valid && pix_ch.ready) || (run_ch.valid && run_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(negedge clk);
		$display("[pixel_run_length_encoder_core] ERROR");
		$finish;
	end

	task automatic queue_pixel(pix_t p);
		pending_pixels.push_back(p);
		pixels_queued++;
	endtask

	function automatic pix_t fill_unused(pix_t p);
		pix_t r;
		r = p;
		for (int k = active_channels(); k < IN_CHANS; k++)
			r[k] = CHAN_W'($urandom_range(0, 255));
		return r;
	endfunction

	task automatic wait_idle();
		while (pixels_taken != pixels_queued || expected_runs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_LINE_WIDTH:     width_reg = val;
			CFG_PICTURE_HEIGHT: height_reg = val;
			CFG_CHANNEL_COUNT:  chan_reg = val[CCNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		pix_t             p;
		int               run_len;
		int               phase_items;
		logic [CFG_W-1:0] h;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pix_ch.valid     = 1'b0;
		pix_ch.pix_chan0 = '0;
		pix_ch.pix_chan1 = '0;
		pix_ch.pix_chan2 = '0;
		pix_ch.pix_chan3 = '0;
		run_ch.ready     = 1'b0;
		pixels_queued    = 0;
		pixels_taken     = 0;
		fail_count       = 0;
		idle_cycles      = 0;
		pix_gap          = 0;
		run_gap          = 0;
		stall_enable     = 1'b1;
		width_reg        = RST_LINE_WIDTH;
		height_reg       = RST_PICTURE_HEIGHT;
		chan_reg         = RST_CHANNEL_COUNT;
		held_pix         = '0;
		run_extra_cnt    = 0;
		run_held         = 1'b0;
		column_cnt       = 0;
		lines_done       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: three channels compared, fourth ignored
		queue_pixel(32'h00000000);
		queue_pixel(32'hFF000000);
		queue_pixel(32'hFFFFFFFF);
		queue_pixel(32'h00FFFFFF);
		queue_pixel(32'hFF00FFFF);
		queue_pixel(32'hFF0000FF);
		queue_pixel(32'h7F000000);
		wait_idle();

		// width shrinks below column: next pixel closes the line, with two records
		write_reg(CFG_LINE_WIDTH, 13'd3);
		write_reg(CFG_PICTURE_HEIGHT, 13'd2);
		write_reg(CFG_CHANNEL_COUNT, 13'd4);
		end_writes();
		queue_pixel(32'h44332211);
		queue_pixel(32'h44332211);
		queue_pixel(32'h44332211);
		queue_pixel(32'h45332211);
		queue_pixel(32'h00000000);
		queue_pixel(32'hFFFFFFFF);
		wait_idle();

		// zero width and zero channel count clamp to one
		write_reg(CFG_PICTURE_HEIGHT, 13'd3);
		write_reg(CFG_LINE_WIDTH, 13'd0);
		write_reg(CFG_CHANNEL_COUNT, 13'd0);
		end_writes();
		queue_pixel(32'hDDCCBBAA);
		queue_pixel(32'h12345678);
		wait_idle();

		// zero height, oversized channel count, unused register index
		write_reg(CFG_PICTURE_HEIGHT, 13'd0);
		write_reg(CFG_CHANNEL_COUNT, 13'd7);
		write_reg(CFG_LINE_WIDTH, 13'd2);
		write_reg(CFG_UNUSED, 13'h1FFF);
		end_writes();
		queue_pixel(32'hFFFFFFFF);
		wait_idle();

		// long run past the 256-pixel cap on an oversized line
		write_reg(CFG_LINE_WIDTH, 13'h1FFF);
		write_reg(CFG_PICTURE_HEIGHT, 13'h1FFF);
		write_reg(CFG_CHANNEL_COUNT, CFG_W'($urandom_range(1, 4)));
		end_writes();
		p = $urandom();
		run_len = $urandom_range(260, 280);
		repeat (run_len) queue_pixel(fill_unused(p));
		repeat ($urandom_range(3, 8)) queue_pixel($urandom());
		wait_idle();

		while (pixels_queued < PIXEL_TARGET) begin
			stall_enable = (pixels_queued < PIXEL_TARGET - CALM_TAIL) &&
				($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       write_reg(CFG_LINE_WIDTH, 13'd0);
					1:       write_reg(CFG_LINE_WIDTH, 13'($urandom_range(9, 40)));
					2:       write_reg(CFG_LINE_WIDTH, $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF);
					default: write_reg(CFG_LINE_WIDTH, 13'($urandom_range(1, 8)));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       h = '0;
					1:       h = 13'h1FFF;
					default: h = lines_done + 13'($urandom_range(0, 4));
				endcase
				write_reg(CFG_PICTURE_HEIGHT, h);
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_CHANNEL_COUNT, CFG_W'($urandom_range(0, 7)));
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_UNUSED, 13'($urandom()));
			end_writes();
			phase_items = $urandom_range(10, 40);
			while (phase_items > 0) begin
				if ($urandom_range(0, 7) == 0) begin
					queue_pixel($urandom());
					phase_items--;
				end else begin
					for (int k = 0; k < IN_CHANS; k++) begin
						case ($urandom_range(0, 2))
							0:       p[k] = 8'h00;
							1:       p[k] = 8'hFF;
							default: p[k] = CHAN_W'($urandom_range(0, 255));
						endcase
					end
					run_len = $urandom_range(1, 6);
					repeat (run_len) queue_pixel(fill_unused(p));
					phase_items -= run_len;
				end
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("[pixel_run_length_encoder_core] OK");
		else
			$display("[pixel_run_length_encoder_core] ERROR");
		$finish;
	end

endmodule
